>>> src/atcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcl_pkg
// Shared types, codes and character constants of the AT command line
// assembler.
// ----------------------------------------------------------------------------
package atcl_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_ADDR,
    ST_RD_EMIT,
    ST_ECHO,
    ST_ACT,
    ST_SCAN,
    ST_REPORT,
    ST_BS1,
    ST_BS2,
    ST_BS3
  } state_t;

  typedef enum logic [2:0] {
    EM_ECHO,
    EM_BS,
    EM_SPACE,
    EM_REPORT,
    EM_READ
  } emit_sel_t;

  // input item kinds
  localparam logic ITEM_CHAR = 1'b0;
  localparam logic ITEM_READ = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // line forms
  localparam logic [3:0] FORM_EMPTY     = 4'd0;
  localparam logic [3:0] FORM_NO_AT     = 4'd1;
  localparam logic [3:0] FORM_AT        = 4'd2;
  localparam logic [3:0] FORM_ATI       = 4'd3;
  localparam logic [3:0] FORM_BASIC     = 4'd4;
  localparam logic [3:0] FORM_EXEC      = 4'd5;
  localparam logic [3:0] FORM_EXEC_ARGS = 4'd6;
  localparam logic [3:0] FORM_QUERY     = 4'd7;
  localparam logic [3:0] FORM_TEST      = 4'd8;

  // configuration register indexes
  localparam logic [7:0] REG_ECHO_ENABLE   = 8'd0;
  localparam logic [7:0] REG_PARSER_ENABLE = 8'd1;

  // characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef struct packed {
    logic      take;
    logic      rd_item;
    logic      scan_start;
    logic      scan_step;
    logic      store_char;
    logic      dec_fill;
    logic      clr_fill;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_kind;
    logic parser_en;
    logic echo_en;
    logic is_crlf;
    logic is_erase;
    logic is_print;
    logic fill_nz;
    logic fill_room;
    logic scan_done;
    logic out_free;
  } status_t;

  // case-insensitive match of a byte against an upper-case ASCII letter
  function automatic logic letter_ci(input logic [7:0] b, input logic [7:0] upper);
    return (b == upper) || (b == (upper + CASE_GAP));
  endfunction

endpackage

>>> src/atcl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcl channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface atcl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_in;
  logic [6:0] read_index;

  modport source (output valid, output kind, output char_in, output read_index,
                  input ready);
  modport sink (input valid, input kind, input char_in, input read_index,
                output ready);
endinterface

interface atcl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] byte_out;
  logic [6:0] line_length;
  logic [3:0] form;
  logic [6:0] name_offset;
  logic [4:0] name_length;
  logic [6:0] args_offset;
  logic       last;

  modport source (output valid, output out_kind, output byte_out, output line_length,
                  output form, output name_offset, output name_length,
                  output args_offset, output last, input ready);
  modport sink (input valid, input out_kind, input byte_out, input line_length,
                input form, input name_offset, input name_length,
                input args_offset, input last, output ready);
endinterface

interface atcl_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/atcl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module atcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/atcl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcl_ctrl
// Sequencer: takes one item, steps echo, edit, line scan and result emission.
// ----------------------------------------------------------------------------
module atcl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  atcl_pkg::status_t status,
  output atcl_pkg::cmd_t    cmd
);

  atcl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atcl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      atcl_pkg::ST_IDLE: begin
        if (status.in_valid) begin
          if (status.in_kind == atcl_pkg::ITEM_READ) begin
            state_next = atcl_pkg::ST_RD_ADDR;
          end else if (!status.parser_en) begin
            state_next = atcl_pkg::ST_IDLE;
          end else if (status.echo_en) begin
            state_next = atcl_pkg::ST_ECHO;
          end else begin
            state_next = atcl_pkg::ST_ACT;
          end
        end
      end
      atcl_pkg::ST_RD_ADDR: state_next = atcl_pkg::ST_RD_EMIT;
      atcl_pkg::ST_RD_EMIT: begin
        if (status.out_free) state_next = atcl_pkg::ST_IDLE;
      end
      atcl_pkg::ST_ECHO: begin
        if (status.out_free) state_next = atcl_pkg::ST_ACT;
      end
      atcl_pkg::ST_ACT: begin
        state_next = atcl_pkg::ST_IDLE;
        if (status.is_crlf && status.fill_nz) begin
          state_next = atcl_pkg::ST_SCAN;
        end else if (status.is_erase && status.fill_nz && status.echo_en) begin
          state_next = atcl_pkg::ST_BS1;
        end
      end
      atcl_pkg::ST_SCAN: begin
        if (status.scan_done) state_next = atcl_pkg::ST_REPORT;
      end
      atcl_pkg::ST_REPORT: begin
        if (status.out_free) state_next = atcl_pkg::ST_IDLE;
      end
      atcl_pkg::ST_BS1: begin
        if (status.out_free) state_next = atcl_pkg::ST_BS2;
      end
      atcl_pkg::ST_BS2: begin
        if (status.out_free) state_next = atcl_pkg::ST_BS3;
      end
      atcl_pkg::ST_BS3: begin
        if (status.out_free) state_next = atcl_pkg::ST_IDLE;
      end
      default: state_next = atcl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.emit_sel = atcl_pkg::EM_ECHO;
    case (state)
      atcl_pkg::ST_IDLE: cmd.take = 1'b1;
      atcl_pkg::ST_RD_ADDR: cmd.rd_item = 1'b1;
      atcl_pkg::ST_RD_EMIT: begin
        cmd.emit      = status.out_free;
        cmd.emit_sel  = atcl_pkg::EM_READ;
        cmd.emit_last = 1'b1;
      end
      atcl_pkg::ST_ECHO: begin
        cmd.emit      = status.out_free;
        cmd.emit_sel  = atcl_pkg::EM_ECHO;
        // more results follow for a report or an erasure of a stored char
        cmd.emit_last = !(status.fill_nz && (status.is_crlf || status.is_erase));
      end
      atcl_pkg::ST_ACT: begin
        if (status.is_crlf) begin
          cmd.scan_start = status.fill_nz;
        end else if (status.is_erase) begin
          cmd.dec_fill = status.fill_nz;
        end else if (status.is_print) begin
          cmd.store_char = status.fill_room;
        end
      end
      atcl_pkg::ST_SCAN: cmd.scan_step = 1'b1;
      atcl_pkg::ST_REPORT: begin
        cmd.emit      = status.out_free;
        cmd.emit_sel  = atcl_pkg::EM_REPORT;
        cmd.emit_last = 1'b1;
        cmd.clr_fill  = status.out_free;
      end
      atcl_pkg::ST_BS1: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = atcl_pkg::EM_BS;
      end
      atcl_pkg::ST_BS2: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = atcl_pkg::EM_SPACE;
      end
      atcl_pkg::ST_BS3: begin
        cmd.emit      = status.out_free;
        cmd.emit_sel  = atcl_pkg::EM_BS;
        cmd.emit_last = 1'b1;
      end
      default: cmd.take = 1'b0;
    endcase
  end

endmodule

>>> src/atcl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcl_datapath
// Item latch, fill count, configuration, line scan and the result register.
// ----------------------------------------------------------------------------
module atcl_datapath #(
  parameter int LINE_MAX = 128,
  parameter int NAME_MAX = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  atcl_in_if.sink                     item,
  atcl_out_if.source                  result,
  atcl_cfg_if.sink                    cfg,
  input  atcl_pkg::cmd_t              cmd,
  output atcl_pkg::status_t           status,
  output logic                        ram_we,
  output logic [$clog2(LINE_MAX)-1:0] ram_waddr,
  output logic [7:0]                  ram_wdata,
  output logic                        ram_re,
  output logic [$clog2(LINE_MAX)-1:0] ram_raddr,
  input  logic [7:0]                  ram_rdata
);

  localparam int PW = $clog2(LINE_MAX);
  localparam int CW = $clog2(NAME_MAX);

  // configuration
  logic echo_en, parser_en;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_en   <= 1'b1;
      parser_en <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        atcl_pkg::REG_ECHO_ENABLE:   echo_en   <= cfg.data[0];
        atcl_pkg::REG_PARSER_ENABLE: parser_en <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // item latch
  logic [7:0]    char_q;
  logic [PW-1:0] idx_q;
  logic          in_range;

  assign item.ready = cmd.take;

  always_ff @(posedge clk) begin
    if (cmd.take && item.valid) begin
      char_q   <= item.char_in;
      idx_q    <= PW'(item.read_index);
      in_range <= 32'(item.read_index) < 32'(LINE_MAX);
    end
  end

  // fill count
  logic [PW-1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.clr_fill) begin
      fill <= '0;
    end else if (cmd.dec_fill) begin
      fill <= fill - 1'b1;
    end else if (cmd.store_char) begin
      fill <= fill + 1'b1;
    end
  end

  // line scan: one read issued per cycle, each byte processed in the cycle after its read
  logic          issue;
  logic [PW-1:0] rd_ptr;
  logic          pend;
  logic [PW-1:0] pend_pos;

  assign issue = cmd.scan_step && (rd_ptr < fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.scan_start) begin
      pend <= 1'b0;
    end else if (cmd.scan_step) begin
      pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_ptr <= '0;
    end else if (issue) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
    if (cmd.scan_step) begin
      pend_pos <= rd_ptr;
    end
  end

  assign ram_we    = cmd.store_char;
  assign ram_waddr = fill;
  assign ram_wdata = char_q;
  assign ram_re    = cmd.rd_item || issue;
  assign ram_raddr = cmd.rd_item ? idx_q : rd_ptr;

  // scan state
  logic          found, found_next;
  logic [PW-1:0] s_pos, s_pos_next;
  logic          cmd_open, cmd_open_next;
  logic [CW-1:0] clen, clen_next;
  logic          a_ok, a_ok_next, t_ok, t_ok_next;
  logic          plus, plus_next, i_ok, i_ok_next;
  logic          have_eq, have_eq_next;
  logic [PW-1:0] eq_pos, eq_pos_next;
  logic          have_q, have_q_next;
  logic          q_first, q_first_next;
  logic          eq_next_q, eq_next_q_next;

  logic [7:0]    b;
  logic          blank, term, at_cmd, in_ext;
  logic [CW-1:0] cidx;

  always_comb begin
    b      = ram_rdata;
    blank  = (b == atcl_pkg::CH_SPACE) || (b == atcl_pkg::CH_TAB);
    term   = (b == atcl_pkg::CH_EQ) || (b == atcl_pkg::CH_QM);
    at_cmd = (!found && !blank) || (found && cmd_open);
    cidx   = found ? clen : '0;
    in_ext = found && ({1'b0, pend_pos} >= ({1'b0, s_pos} + (PW+1)'(3)));

    found_next     = found;
    s_pos_next     = s_pos;
    cmd_open_next  = cmd_open;
    clen_next      = clen;
    a_ok_next      = a_ok;
    t_ok_next      = t_ok;
    plus_next      = plus;
    i_ok_next      = i_ok;
    have_eq_next   = have_eq;
    eq_pos_next    = eq_pos;
    have_q_next    = have_q;
    q_first_next   = q_first;
    eq_next_q_next = eq_next_q;

    if (!found && !blank) begin
      found_next = 1'b1;
      s_pos_next = pend_pos;
    end

    if (at_cmd) begin
      if (term) begin
        cmd_open_next = 1'b0;
        clen_next     = cidx;
      end else begin
        case (32'(cidx))
          0: a_ok_next = atcl_pkg::letter_ci(b, atcl_pkg::CH_A);
          1: t_ok_next = atcl_pkg::letter_ci(b, atcl_pkg::CH_T);
          2: begin
            plus_next = (b == atcl_pkg::CH_PLUS);
            i_ok_next = atcl_pkg::letter_ci(b, atcl_pkg::CH_I);
          end
          default: ;
        endcase
        clen_next     = cidx + 1'b1;
        cmd_open_next = (32'(cidx) + 1) < (NAME_MAX - 1);
      end
    end

    if (in_ext) begin
      if (have_eq && (({1'b0, eq_pos} + 1'b1) == {1'b0, pend_pos}) &&
          (b == atcl_pkg::CH_QM)) begin
        eq_next_q_next = 1'b1;
      end
      if (!have_eq && (b == atcl_pkg::CH_EQ)) begin
        have_eq_next = 1'b1;
        eq_pos_next  = pend_pos;
      end
      if (!have_q && (b == atcl_pkg::CH_QM)) begin
        have_q_next  = 1'b1;
        q_first_next = !have_eq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      found     <= 1'b0;
      cmd_open  <= 1'b1;
      clen      <= '0;
      have_eq   <= 1'b0;
      have_q    <= 1'b0;
      q_first   <= 1'b0;
      eq_next_q <= 1'b0;
    end else if (cmd.scan_step && pend) begin
      found     <= found_next;
      s_pos     <= s_pos_next;
      cmd_open  <= cmd_open_next;
      clen      <= clen_next;
      a_ok      <= a_ok_next;
      t_ok      <= t_ok_next;
      plus      <= plus_next;
      i_ok      <= i_ok_next;
      have_eq   <= have_eq_next;
      eq_pos    <= eq_pos_next;
      have_q    <= have_q_next;
      q_first   <= q_first_next;
      eq_next_q <= eq_next_q_next;
    end
  end

  // line form from the scan summary
  logic [3:0] rpt_form;
  logic [6:0] rpt_noff, rpt_aoff;
  logic [4:0] rpt_nlen;

  always_comb begin
    rpt_form = atcl_pkg::FORM_EMPTY;
    rpt_noff = '0;
    rpt_nlen = '0;
    rpt_aoff = '0;
    if (found) begin
      if ((32'(clen) < 2) || !a_ok || !t_ok) begin
        rpt_form = atcl_pkg::FORM_NO_AT;
      end else if (32'(clen) == 2) begin
        rpt_form = atcl_pkg::FORM_AT;
      end else if (!plus) begin
        rpt_form = ((32'(clen) == 3) && i_ok) ? atcl_pkg::FORM_ATI : atcl_pkg::FORM_BASIC;
      end else begin
        rpt_noff = 7'(32'(s_pos) + 3);
        rpt_nlen = 5'(32'(clen) - 3);
        if (q_first) begin
          rpt_form = atcl_pkg::FORM_QUERY;
        end else if (have_eq) begin
          if (eq_next_q) begin
            rpt_form = atcl_pkg::FORM_TEST;
          end else begin
            rpt_form = atcl_pkg::FORM_EXEC_ARGS;
            rpt_aoff = 7'(32'(eq_pos) + 1);
          end
        end else begin
          rpt_form = atcl_pkg::FORM_EXEC;
        end
      end
    end
  end

  // result register
  logic       out_valid;
  logic [1:0] o_kind;
  logic [7:0] o_byte;
  logic [6:0] o_len, o_noff, o_aoff;
  logic [3:0] o_form;
  logic [4:0] o_nlen;
  logic       o_last;
  logic       out_free;

  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_kind <= atcl_pkg::KIND_ECHO;
      o_byte <= '0;
      o_len  <= '0;
      o_form <= '0;
      o_noff <= '0;
      o_nlen <= '0;
      o_aoff <= '0;
      o_last <= cmd.emit_last;
      case (cmd.emit_sel)
        atcl_pkg::EM_ECHO:  o_byte <= char_q;
        atcl_pkg::EM_BS:    o_byte <= atcl_pkg::CH_BS;
        atcl_pkg::EM_SPACE: o_byte <= atcl_pkg::CH_SPACE;
        atcl_pkg::EM_REPORT: begin
          o_kind <= atcl_pkg::KIND_REPORT;
          o_len  <= 7'(fill);
          o_form <= rpt_form;
          o_noff <= rpt_noff;
          o_nlen <= rpt_nlen;
          o_aoff <= rpt_aoff;
        end
        atcl_pkg::EM_READ: begin
          o_kind <= atcl_pkg::KIND_READ;
          o_byte <= in_range ? ram_rdata : 8'h00;
        end
        default: o_byte <= char_q;
      endcase
    end
  end

  assign result.valid       = out_valid;
  assign result.out_kind    = o_kind;
  assign result.byte_out    = o_byte;
  assign result.line_length = o_len;
  assign result.form        = o_form;
  assign result.name_offset = o_noff;
  assign result.name_length = o_nlen;
  assign result.args_offset = o_aoff;
  assign result.last        = o_last;

  // status
  always_comb begin
    status.in_valid  = item.valid;
    status.in_kind   = item.kind;
    status.parser_en = parser_en;
    status.echo_en   = echo_en;
    status.is_crlf   = (char_q == atcl_pkg::CH_CR) || (char_q == atcl_pkg::CH_LF);
    status.is_erase  = (char_q == atcl_pkg::CH_BS) || (char_q == atcl_pkg::CH_DEL);
    status.is_print  = (char_q >= atcl_pkg::CH_SPACE) && (char_q != atcl_pkg::CH_DEL);
    status.fill_nz   = (fill != '0);
    status.fill_room = 32'(fill) < (LINE_MAX - 1);
    status.scan_done = (rd_ptr == fill) && !pend;
    status.out_free  = out_free;
  end

endmodule

>>> src/at_command_line_assembler.sv
`timescale 1ns / 1ps
// Read item: the index is latched, the line store is read and the result is
// registered before the next item is taken. Character: optional echo, then
// the edit step, then backspace, space, backspace for an erase with echo;
// line end walks the line store one byte a cycle via its read port, then
// reports, waiting out output stalls. Reset clears the fill count and sets
// echo and parser enable; line store contents stay undefined until written.
// ----------------------------------------------------------------------------
// at_command_line_assembler
// Echoes and assembles received characters into a line and classifies the
// AT command form on line end; serves reads of the stored line.
// ----------------------------------------------------------------------------
module at_command_line_assembler #(
  parameter int LINE_MAX = 128,
  parameter int NAME_MAX = 32
) (
  input logic        clk,
  input logic        rst,
  atcl_in_if.sink    item,
  atcl_out_if.source result,
  atcl_cfg_if.sink   cfg
);

  localparam int PW = $clog2(LINE_MAX);

  atcl_pkg::cmd_t    cmd;
  atcl_pkg::status_t status;

  logic          ram_we, ram_re;
  logic [PW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  atcl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  atcl_datapath #(
    .LINE_MAX (LINE_MAX),
    .NAME_MAX (NAME_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  atcl_ram #(
    .WIDTH (8),
    .DEPTH (LINE_MAX)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
